// ===== rtl/command_smoother_assert.svh =====
// Assertion macros used by cs_ctrl
`ifndef COMMAND_SMOOTHER_ASSERT_SVH
`define COMMAND_SMOOTHER_ASSERT_SVH

`ifndef ASSERT_OFF

`define CS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("command_smoother: assertion failed");

`define CS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("command_smoother: assertion failed");

`else

`define CS_ASSERT_IMPLIES(label, clk, rstn, ante, cons)

`define CS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/cs_pkg.sv =====
package cs_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int WEIGHT_BITS    = 17;
    localparam int WEIGHT_FRAC    = 16;
    localparam int WIN_BITS       = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 17;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = 17'h10000;
    localparam logic [WIN_BITS-1:0]    WINDOW_RESET = 5'd4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_WEIGHT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AVERAGE_MODE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t steer_sample;
        sample_t accel_sample;
    } in_t;

    typedef struct packed {
        sample_t steer_out;
        sample_t accel_out;
    } out_t;

    typedef enum logic [1:0] {
        SRC_PASS,
        SRC_BLEND,
        SRC_QUOT
    } src_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic ram_we;
        logic ram_raw;
        logic acc_clear;
        logic acc_en;
        logic div_start;
        logic commit;
        src_t src;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

endpackage

// ===== rtl/cs_ram.sv =====
module cs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cs_div.sv =====
module cs_div #(
    parameter int DIVIDEND_W = 21
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [DIVIDEND_W-1:0]        dividend,
    input  logic [cs_pkg::WIN_BITS-1:0]         divisor,
    output logic                                done,
    output logic signed [DIVIDEND_W-1:0]        quotient
);

    localparam int DIV_W = cs_pkg::WIN_BITS;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] mag_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [DIV_W:0]        trial;
    logic                  fits;
    logic [DIV_W:0]        rem_next;

    always_comb begin
        trial    = {rem_reg, mag_reg[DIVIDEND_W-1]};
        fits     = trial >= {1'b0, divisor};
        rem_next = fits ? (trial - {1'b0, divisor}) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(DIVIDEND_W);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DIVIDEND_W-1];
            mag_reg <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next[DIV_W-1:0];
            mag_reg <= {mag_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(mag_reg) : signed'(mag_reg);

endmodule

// ===== rtl/cs_ctrl.sv =====
`include "command_smoother_assert.svh"

module cs_ctrl #(
    parameter int RING_DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_valid,
    output logic                                          s_ready,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    input  logic                                          mode,
    input  logic [cs_pkg::WIN_BITS-1:0]                   h,
    input  cs_pkg::stat_t                                 stat,
    output cs_pkg::cmd_t                                  cmd,
    output logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] ram_waddr,
    output logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] ram_raddr
);

    localparam int WIN_W = cs_pkg::WIN_BITS;
    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_AVG_WR,
        S_AVG_RD,
        S_AVG_LAST,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic [WIN_W-1:0]   warm_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [WIN_W-1:0]   rd_cnt_reg;
    logic               rd_pend_reg;
    cs_pkg::src_t       src_reg;
    logic               m_valid_reg;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic               avg_go;
    logic [IDX_W-1:0]   slot_eff;
    logic [IDX_W-1:0]   slot_next;

    always_comb begin
        accept    = s_valid && (state_reg == S_IDLE);
        out_free  = !m_valid_reg || m_ready;
        commit    = (state_reg == S_FINISH) && out_free;
        avg_go    = mode && (warm_reg >= h);
        slot_eff  = (int'(slot_reg) >= int'(h)) ? '0 : slot_reg;
        slot_next = (int'(slot_eff) + 1 >= int'(h)) ? '0 : IDX_W'(int'(slot_eff) + 1);
    end

    always_comb begin
        cmd.load_in   = accept;
        cmd.mul       = (state_reg == S_MUL);
        cmd.ram_raw   = (state_reg == S_AVG_WR);
        cmd.ram_we    = (state_reg == S_AVG_WR)
                        || (commit && mode && (src_reg != cs_pkg::SRC_QUOT));
        cmd.acc_clear = (state_reg == S_AVG_WR);
        cmd.acc_en    = rd_pend_reg;
        cmd.div_start = (state_reg == S_DIV_GO);
        cmd.commit    = commit;
        cmd.src       = src_reg;
        ram_waddr     = (state_reg == S_AVG_WR) ? slot_eff : IDX_W'(warm_reg);
        ram_raddr     = IDX_W'(rd_cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            warm_reg    <= '0;
            slot_reg    <= '0;
            rd_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
            src_reg     <= cs_pkg::SRC_PASS;
            m_valid_reg <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == S_AVG_RD);
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (avg_go) begin
                            src_reg   <= cs_pkg::SRC_QUOT;
                            state_reg <= S_AVG_WR;
                        end else if (warm_reg == '0) begin
                            src_reg   <= cs_pkg::SRC_PASS;
                            state_reg <= S_FINISH;
                        end else begin
                            src_reg   <= cs_pkg::SRC_BLEND;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    state_reg <= S_FINISH;
                end
                S_AVG_WR: begin
                    slot_reg   <= slot_next;
                    rd_cnt_reg <= '0;
                    state_reg  <= S_AVG_RD;
                end
                S_AVG_RD: begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == h - 1'b1) begin
                        state_reg <= S_AVG_LAST;
                    end
                end
                S_AVG_LAST: begin
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (stat.div_done) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        if (src_reg != cs_pkg::SRC_QUOT) begin
                            if (mode) begin
                                warm_reg <= warm_reg + 1'b1;
                            end else if (warm_reg == '0) begin
                                warm_reg <= WIN_W'(1);
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `CS_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, state_reg != S_IDLE)
    `CS_ASSERT_NEXT(a_commit_valid, aclk, aresetn, commit, m_valid_reg)
    `CS_ASSERT_IMPLIES(a_div_done_wait, aclk, aresetn, stat.div_done, state_reg == S_DIV_WAIT)

endmodule

// ===== rtl/cs_dp.sv =====
module cs_dp #(
    parameter int RING_DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  cs_pkg::in_t                                   s_data,
    output cs_pkg::out_t                                  m_data,
    input  logic [cs_pkg::WEIGHT_BITS-1:0]                weight,
    input  logic [cs_pkg::WIN_BITS-1:0]                   h,
    input  cs_pkg::cmd_t                                  cmd,
    output cs_pkg::stat_t                                 stat,
    input  logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] ram_waddr,
    input  logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] ram_raddr
);

    localparam int SB         = cs_pkg::SAMPLE_BITS;
    localparam int WB         = cs_pkg::WEIGHT_BITS;
    localparam int FRAC       = cs_pkg::WEIGHT_FRAC;
    localparam int PROD_W     = SB + WB + 2;
    localparam int ACC_W      = SB + $clog2(RING_DEPTH + 1);
    localparam int ROUND_HALF = 1 << (FRAC - 1);

    cs_pkg::in_t                 x_reg;
    cs_pkg::out_t                out_reg;
    logic signed [PROD_W-1:0]    prod_s_reg;
    logic signed [PROD_W-1:0]    prod_a_reg;
    logic signed [ACC_W-1:0]     sum_s_reg;
    logic signed [ACC_W-1:0]     sum_a_reg;

    logic signed [WB:0]          w_s;
    logic signed [SB:0]          diff_s;
    logic signed [SB:0]          diff_a;
    logic signed [PROD_W-1:0]    prod_s;
    logic signed [PROD_W-1:0]    prod_a;
    logic signed [PROD_W-1:0]    step_s;
    logic signed [PROD_W-1:0]    step_a;
    cs_pkg::out_t                res;
    logic [2*SB-1:0]             ram_wdata;
    logic [2*SB-1:0]             ram_rdata;
    logic                        done_s;
    logic                        done_a;
    logic signed [ACC_W-1:0]     quot_s;
    logic signed [ACC_W-1:0]     quot_a;

    always_comb begin
        w_s    = signed'({1'b0, weight});
        diff_s = {x_reg.steer_sample[SB-1], x_reg.steer_sample}
                 - {out_reg.steer_out[SB-1], out_reg.steer_out};
        diff_a = {x_reg.accel_sample[SB-1], x_reg.accel_sample}
                 - {out_reg.accel_out[SB-1], out_reg.accel_out};
        prod_s = w_s * diff_s;
        prod_a = w_s * diff_a;
        step_s = (prod_s_reg + PROD_W'(ROUND_HALF)) >>> FRAC;
        step_a = (prod_a_reg + PROD_W'(ROUND_HALF)) >>> FRAC;
    end

    always_comb begin
        case (cmd.src)
            cs_pkg::SRC_PASS: begin
                res.steer_out = x_reg.steer_sample;
                res.accel_out = x_reg.accel_sample;
            end
            cs_pkg::SRC_BLEND: begin
                res.steer_out = out_reg.steer_out + step_s[SB-1:0];
                res.accel_out = out_reg.accel_out + step_a[SB-1:0];
            end
            cs_pkg::SRC_QUOT: begin
                res.steer_out = quot_s[SB-1:0];
                res.accel_out = quot_a[SB-1:0];
            end
            default: begin
                res.steer_out = x_reg.steer_sample;
                res.accel_out = x_reg.accel_sample;
            end
        endcase
        ram_wdata = cmd.ram_raw ? {x_reg.steer_sample, x_reg.accel_sample}
                                : {res.steer_out, res.accel_out};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg <= s_data;
        end
        if (cmd.mul) begin
            prod_s_reg <= prod_s;
            prod_a_reg <= prod_a;
        end
        if (cmd.acc_clear) begin
            sum_s_reg <= '0;
            sum_a_reg <= '0;
        end else if (cmd.acc_en) begin
            sum_s_reg <= sum_s_reg + ACC_W'(signed'(ram_rdata[2*SB-1:SB]));
            sum_a_reg <= sum_a_reg + ACC_W'(signed'(ram_rdata[SB-1:0]));
        end
        if (cmd.commit) begin
            out_reg <= res;
        end
    end

    cs_ram #(
        .WIDTH (2 * SB),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cs_div #(
        .DIVIDEND_W (ACC_W)
    ) u_div_steer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_s_reg),
        .divisor  (h),
        .done     (done_s),
        .quotient (quot_s)
    );

    cs_div #(
        .DIVIDEND_W (ACC_W)
    ) u_div_accel (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_a_reg),
        .divisor  (h),
        .done     (done_a),
        .quotient (quot_a)
    );

    assign stat.div_done = done_s && done_a;
    assign m_data        = out_reg;

endmodule

// ===== rtl/command_smoother.sv =====
// Two-channel command smoother (steer, accel). Each transaction on s_ carries one raw
// sample pair and yields exactly one smoothed pair on m_. The first sample after reset
// passes straight through; later samples are blended with the last output using the
// Q1.16 blend_weight, rounded to nearest. With average_mode set, the first h outputs
// (h = window_length clamped to 1..RING_DEPTH) are made as above and stored in the
// history ring; after that each raw sample replaces the oldest entry and the output is
// the ring sum divided by h, truncated toward zero. One transaction is in work at a
// time; a finished result waits in the output register while the next one is accepted.
// An averaged sample is paced by the serial ring read-out (one entry per cycle) and the
// bit-serial divider (one quotient bit per cycle over the ACC_W-bit sum). Write
// registers on cfg_ only while idle.
module command_smoother #(
    parameter int RING_DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  cs_pkg::in_t                          s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output cs_pkg::out_t                         m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [cs_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int WIN_W = cs_pkg::WIN_BITS;
    localparam int WB    = cs_pkg::WEIGHT_BITS;
    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic [WB-1:0]    weight_reg;
    logic             mode_reg;
    logic [WIN_W-1:0] window_reg;

    logic [WB-1:0]    weight_eff;
    logic [WIN_W-1:0] window_eff;
    cs_pkg::cmd_t     cmd;
    cs_pkg::stat_t    stat;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= cs_pkg::WEIGHT_ONE;
            mode_reg   <= 1'b0;
            window_reg <= cs_pkg::WINDOW_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                cs_pkg::REG_BLEND_WEIGHT: begin
                    weight_reg <= cfg_data[WB-1:0];
                end
                cs_pkg::REG_AVERAGE_MODE: begin
                    mode_reg <= cfg_data[0];
                end
                cs_pkg::REG_WINDOW_LENGTH: begin
                    window_reg <= cfg_data[WIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        weight_eff = (weight_reg > cs_pkg::WEIGHT_ONE) ? cs_pkg::WEIGHT_ONE : weight_reg;
        if (window_reg == '0) begin
            window_eff = WIN_W'(1);
        end else if (int'(window_reg) > RING_DEPTH) begin
            window_eff = WIN_W'(RING_DEPTH);
        end else begin
            window_eff = window_reg;
        end
    end

    assign cfg_ready = 1'b1;

    cs_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .mode      (mode_reg),
        .h         (window_eff),
        .stat      (stat),
        .cmd       (cmd),
        .ram_waddr (ram_waddr),
        .ram_raddr (ram_raddr)
    );

    cs_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .weight    (weight_eff),
        .h         (window_eff),
        .cmd       (cmd),
        .stat      (stat),
        .ram_waddr (ram_waddr),
        .ram_raddr (ram_raddr)
    );

endmodule

// ===== tb/sv/command_smoother_tb.sv =====
`timescale 1ns / 100ps

module command_smoother_tb;
    import cs_pkg::*;

    localparam int HIST_DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS = 410;
    localparam longint UNITY = longint'(WEIGHT_ONE);
    localparam longint SAMPLE_BIAS = longint'(1) << (SAMPLE_BITS - 1);
    localparam longint ROUND_HALF = longint'(1) << (WEIGHT_FRAC - 1);
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_BLEND_WEIGHT;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;

    logic [WEIGHT_BITS-1:0] cur_weight = WEIGHT_ONE;
    logic cur_avg = 1'b0;
    logic [WIN_BITS-1:0] cur_window = WINDOW_RESET;
    int warm_cnt = 0;
    sample_t last_steer = '0;
    sample_t last_accel = '0;
    sample_t hist_steer [HIST_DEPTH];
    sample_t hist_accel [HIST_DEPTH];
    int hist_slot = 0;
    out_t pending_outputs [$];

    command_smoother #(
        .RING_DEPTH(HIST_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic sample_t mix(input sample_t x, input sample_t p, input longint w);
        longint acc;
        acc = w * (longint'(x) + SAMPLE_BIAS) + (UNITY - w) * (longint'(p) + SAMPLE_BIAS)
            + ROUND_HALF;
        return sample_t'((acc >>> WEIGHT_FRAC) - SAMPLE_BIAS);
    endfunction

    function automatic out_t smooth_step(input in_t item);
        longint w;
        longint sum_s;
        longint sum_a;
        int h;
        out_t res;
        w = (cur_weight > WEIGHT_ONE) ? UNITY : longint'(cur_weight);
        h = (cur_window == 0) ? 1 : (cur_window > HIST_DEPTH) ? HIST_DEPTH : int'(cur_window);
        if (!cur_avg || warm_cnt < h) begin
            if (warm_cnt == 0) begin
                res.steer_out = item.steer_sample;
                res.accel_out = item.accel_sample;
            end else begin
                res.steer_out = mix(item.steer_sample, last_steer, w);
                res.accel_out = mix(item.accel_sample, last_accel, w);
            end
            if (cur_avg) begin
                hist_steer[warm_cnt] = res.steer_out;
                hist_accel[warm_cnt] = res.accel_out;
                warm_cnt++;
            end else if (warm_cnt == 0) begin
                warm_cnt = 1;
            end
        end else begin
            if (hist_slot >= h) hist_slot = 0;
            hist_steer[hist_slot] = item.steer_sample;
            hist_accel[hist_slot] = item.accel_sample;
            sum_s = 0;
            sum_a = 0;
            for (int i = 0; i < h; i++) begin
                sum_s += longint'(hist_steer[i]);
                sum_a += longint'(hist_accel[i]);
            end
            res.steer_out = sample_t'(sum_s / h);
            res.accel_out = sample_t'(sum_a / h);
            hist_slot++;
            if (hist_slot >= h) hist_slot = 0;
        end
        last_steer = res.steer_out;
        last_accel = res.accel_out;
        return res;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // drop the input channel, wait for the block to drain, then program all registers
    task automatic configure(input logic [WEIGHT_BITS-1:0] weight, input logic mode,
                             input logic [WIN_BITS-1:0] window);
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        write_reg(REG_BLEND_WEIGHT, CFG_DATA_BITS'(weight));
        write_reg(REG_AVERAGE_MODE, CFG_DATA_BITS'(mode));
        write_reg(REG_WINDOW_LENGTH, CFG_DATA_BITS'(window));
        cur_weight = weight;
        cur_avg = mode;
        cur_window = window;
    endtask

    task automatic send_sample(input sample_t steer, input sample_t accel);
        in_t item;
        out_t expected;
        item.steer_sample = steer;
        item.accel_sample = accel;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected = smooth_step(item);
        pending_outputs = {pending_outputs, expected};
    endtask

    // first sample must land in average mode so the ring fills from entry zero
    task automatic test_warmup_and_average();
        configure(WEIGHT_ONE >> 1, 1'b1, 5'd31);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample('0, sample_t'(-1));
        send_sample(sample_t'(-1), '0);
        repeat (12) send_sample(random_sample(), random_sample());
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
    endtask

    task automatic test_window_limits();
        configure(WEIGHT_ONE >> 1, 1'b1, 5'd0);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        configure(WEIGHT_ONE >> 1, 1'b1, 5'd3);
        send_sample(random_sample(), random_sample());
        send_sample(random_sample(), random_sample());
    endtask

    task automatic test_blend_weights();
        configure({WEIGHT_BITS{1'b1}}, 1'b0, WINDOW_RESET);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        configure('0, 1'b0, WINDOW_RESET);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        configure(WEIGHT_BITS'(1), 1'b0, WINDOW_RESET);
        send_sample(random_sample(), random_sample());
        configure(WEIGHT_BITS'(WEIGHT_ONE - 1), 1'b0, WINDOW_RESET);
        send_sample(random_sample(), random_sample());
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
        int sent;
        int chunk;
        logic [WEIGHT_BITS-1:0] weight;
        logic [WIN_BITS-1:0] window;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(0, 5))
                0: weight = '0;
                1: weight = WEIGHT_ONE;
                2: weight = WEIGHT_BITS'($urandom_range(65537, 131071));
                default: weight = WEIGHT_BITS'($urandom_range(0, 65536));
            endcase
            window = ($urandom_range(0, 7) == 0) ? WIN_BITS'($urandom_range(0, 31))
                                                  : WIN_BITS'($urandom_range(1, 6));
            configure(weight, 1'($urandom_range(0, 1)), window);
            chunk = $urandom_range(10, 60);
            for (int i = 0; i < chunk && sent < items; i++) begin
                send_sample(random_sample(), random_sample());
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected transaction: steer_out %0d accel_out %0d",
                       m_data.steer_out, m_data.accel_out);
                error_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_data.steer_out !== want.steer_out) begin
                    $error("steer_out: expected %0d, got %0d", want.steer_out, m_data.steer_out);
                    error_count++;
                end
                if (m_data.accel_out !== want.accel_out) begin
                    $error("accel_out: expected %0d, got %0d", want.accel_out, m_data.accel_out);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_warmup_and_average();
        test_window_limits();
        test_blend_weights();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 78, 0);
        test_random_traffic(PHASE_ITEMS, 0, 78);
        test_random_traffic(PHASE_ITEMS, 25, 25);
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
